### rtl/gtgl_pkg.sv
// ----------------------------------------------------------------------------
// gtgl_pkg: shared types and constants for the glyph layout core
// Command format between front and back, coordinate saturation, register map.
// ----------------------------------------------------------------------------
package gtgl_pkg;

  // Pen coordinate width; saturation limits follow from it
  localparam int COORD_BITS = 16;
  // Wide enough for any pen value plus an advance, up to 32-bit coordinates
  localparam int CALC_W     = 34;
  localparam int CFG_W      = 16;
  localparam int ADDR_W     = 32;
  localparam int COLOR_W    = 24;
  localparam int NOFF_W     = 12;
  localparam int GWIDTH_W   = 5;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CALC_W-1:0]     calc_t;

  localparam calc_t COORD_MAX = calc_t'((longint'(1) << (COORD_BITS - 1)) - 1);
  localparam calc_t COORD_MIN = calc_t'(-(longint'(1) << (COORD_BITS - 1)));

  // Text constants
  localparam logic [7:0] LEAD_MIN   = 8'd160;
  localparam logic [7:0] CODE_BIAS  = 8'd161;
  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam int         ROW_CELLS  = 94;
  localparam int         WIDE_BYTES = 24;
  localparam int         NARROW_BYTES = 12;

  // Pen movement
  localparam calc_t ADV_WIDE   = calc_t'(13);
  localparam calc_t ADV_NARROW = calc_t'(6);
  localparam calc_t LINE_STEP  = calc_t'(12);

  localparam logic [GWIDTH_W-1:0] WIDTH_WIDE   = GWIDTH_W'(16);
  localparam logic [GWIDTH_W-1:0] WIDTH_NARROW = GWIDTH_W'(8);

  // Register indexes (byte address 4*i)
  localparam logic [2:0] REG_START_X   = 3'd0;
  localparam logic [2:0] REG_START_Y   = 3'd1;
  localparam logic [2:0] REG_WIDE_BASE = 3'd2;
  localparam logic [2:0] REG_NARROW_BASE = 3'd3;
  localparam logic [2:0] REG_INK       = 3'd4;

  // Queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_NARROW,
    CMD_WIDE,
    CMD_HOME,
    CMD_NEWLINE
  } cmd_kind_e;

  // One queued command; flush draws a held lead byte as narrow first
  typedef struct packed {
    cmd_kind_e           kind;
    logic                flush;
    logic [NOFF_W-1:0]   flush_off;
    logic [ADDR_W-1:0]   off;
  } cmd_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] start_x;
    logic signed [CFG_W-1:0] start_y;
    logic [ADDR_W-1:0]       wide_base;
    logic [ADDR_W-1:0]       narrow_base;
    logic [COLOR_W-1:0]      ink;
  } cfg_t;

  // Pen load on a start register write; start carries the value being written
  typedef struct packed {
    logic                    load_x;
    logic                    load_y;
    logic signed [CFG_W-1:0] start;
  } cfg_load_t;

  function automatic coord_t sat_coord(calc_t v);
    if (v > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

endpackage

### rtl/gtgl_front.sv
// ----------------------------------------------------------------------------
// gtgl_front: byte intake and classification
// Holds a pending lead byte, pairs it with the next byte and precomputes
// glyph offsets, then pushes one command per byte that needs work.
// ----------------------------------------------------------------------------
module gtgl_front import gtgl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] text_byte_i,
  output logic       in_stall_o,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_lead_q, held_lead_d;
  logic       accept;
  logic       is_lead;
  logic [ADDR_W-1:0] row_idx, col_idx;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_lead    = text_byte_i >= LEAD_MIN;

  // Wide offset: (col + row*94) * 24, wrapping at 32 bits
  assign row_idx = {24'b0, held_lead_q} - ADDR_W'(CODE_BIAS);
  assign col_idx = {24'b0, text_byte_i} - ADDR_W'(CODE_BIAS);

  // Classify the byte
  always_comb begin
    held_valid_d    = held_valid_q;
    held_lead_d     = held_lead_q;
    push_o          = 1'b0;
    cmd_o.kind      = CMD_NARROW;
    cmd_o.flush     = held_valid_q;
    cmd_o.flush_off = NOFF_W'(held_lead_q) * NOFF_W'(NARROW_BYTES);
    cmd_o.off       = ADDR_W'(NOFF_W'(text_byte_i) * NOFF_W'(NARROW_BYTES));
    if (accept) begin
      held_valid_d = 1'b0;
      held_lead_d  = 8'd0;
      if (held_valid_q && is_lead) begin
        push_o      = 1'b1;
        cmd_o.kind  = CMD_WIDE;
        cmd_o.flush = 1'b0;
        cmd_o.off   = (col_idx + row_idx * ADDR_W'(ROW_CELLS)) * ADDR_W'(WIDE_BYTES);
      end else if (is_lead) begin
        // nothing held: keep the lead byte, no work yet
        held_valid_d = 1'b1;
        held_lead_d  = text_byte_i;
      end else if (text_byte_i == BYTE_NUL) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_HOME;
      end else if (text_byte_i == BYTE_LF) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_NEWLINE;
      end else begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_NARROW;
      end
    end
  end

  // Hold the lead byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_lead_q  <= 8'd0;
    end else begin
      held_valid_q <= held_valid_d;
      held_lead_q  <= held_lead_d;
    end
  end

endmodule

### rtl/gtgl_queue.sv
// ----------------------------------------------------------------------------
// gtgl_queue: short command queue
// Decouples the byte intake from glyph emission so each side stalls alone.
// ----------------------------------------------------------------------------
module gtgl_queue import gtgl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o       = count_q == (QPTR_W + 1)'(QDEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = slot_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/gtgl_back.sv
// ----------------------------------------------------------------------------
// gtgl_back: pen tracking and glyph command emission
// Executes queued commands, one glyph per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module gtgl_back import gtgl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  cmd_t                 head_i,
  output logic                 pop_o,
  input  cfg_t                 cfg_i,
  input  cfg_load_t            load_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output coord_t               pen_x_o,
  output coord_t               pen_y_o,
  output logic [GWIDTH_W-1:0]  glyph_width_o,
  output logic [ADDR_W-1:0]    glyph_address_o,
  output logic                 is_wide_o,
  output logic [COLOR_W-1:0]   glyph_color_o,
  output logic                 last_of_run_o
);

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic   pre_done_q, pre_done_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, emit, wide, last;
  logic [ADDR_W-1:0] addr;
  logic   tail_only;

  coord_t home_x, home_y, load_pos;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign tail_only = head_i.kind == CMD_HOME || head_i.kind == CMD_NEWLINE;
  assign home_x    = sat_coord(calc_t'(cfg_i.start_x));
  assign home_y    = sat_coord(calc_t'(cfg_i.start_y));
  assign load_pos  = sat_coord(calc_t'(load_i.start));

  // Run the head command
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    pre_done_d = pre_done_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    wide       = 1'b0;
    last       = 1'b1;
    addr       = cfg_i.narrow_base + ADDR_W'(head_i.flush_off);
    if (head_valid_i && head_i.flush && !pre_done_q) begin
      // draw the held lead byte on its own
      last = tail_only;
      if (out_free) begin
        emit       = 1'b1;
        pre_done_d = 1'b1;
        cur_x_d    = sat_coord(calc_t'(cur_x_q) + ADV_NARROW);
      end
    end else if (head_valid_i) begin
      case (head_i.kind)
        CMD_NARROW, CMD_WIDE: begin
          wide = head_i.kind == CMD_WIDE;
          addr = (wide ? cfg_i.wide_base : cfg_i.narrow_base) + head_i.off;
          if (out_free) begin
            emit       = 1'b1;
            pop_o      = 1'b1;
            pre_done_d = 1'b0;
            cur_x_d    = sat_coord(calc_t'(cur_x_q) + (wide ? ADV_WIDE : ADV_NARROW));
          end
        end
        CMD_HOME: begin
          pop_o      = 1'b1;
          pre_done_d = 1'b0;
          cur_x_d    = home_x;
          cur_y_d    = home_y;
        end
        CMD_NEWLINE: begin
          pop_o      = 1'b1;
          pre_done_d = 1'b0;
          if (!head_i.flush || pre_done_q) begin
            cur_x_d = home_x;
            cur_y_d = sat_coord(calc_t'(cur_y_q) + LINE_STEP);
          end
        end
        default: begin
          pop_o      = 1'b1;
          pre_done_d = 1'b0;
        end
      endcase
    end
    if (load_i.load_x) begin
      cur_x_d = load_pos;
    end
    if (load_i.load_y) begin
      cur_y_d = load_pos;
    end
  end

  // Hold or drop the output beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      pre_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      pre_done_q  <= pre_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pen_x_o         <= cur_x_q;
      pen_y_o         <= cur_y_q;
      glyph_width_o   <= wide ? WIDTH_WIDE : WIDTH_NARROW;
      glyph_address_o <= addr;
      is_wide_o       <= wide;
      glyph_color_o   <= cfg_i.ink;
      last_of_run_o   <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/gb2312_text_glyph_layout_core.sv
// ----------------------------------------------------------------------------
// gb2312_text_glyph_layout_core: text to glyph command layout
// Turns a byte stream into draw commands for a 12-pixel double-byte font.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    text_byte_i
//   out      out_valid_o / out_stall_i  pen_x_o pen_y_o glyph_width_o
//                                       glyph_address_o is_wide_o
//                                       glyph_color_o last_of_run_o
//   cfg      psel penable pwrite pready paddr pwdata prdata
//
// One byte is taken per cycle while the queue is not full. A byte that
// causes two glyphs (held lead byte flushed, then an ordinary glyph) holds
// the back end for both glyphs; the four-entry command queue absorbs that.
// Reset clears the held byte, the queue and the pen; no clearing pass.
// in_stall_o rises only when the queue is full.
// ----------------------------------------------------------------------------
module gb2312_text_glyph_layout_core import gtgl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid_i,
  input  logic [7:0]          text_byte_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output coord_t              pen_x_o,
  output coord_t              pen_y_o,
  output logic [GWIDTH_W-1:0] glyph_width_o,
  output logic [ADDR_W-1:0]   glyph_address_o,
  output logic                is_wide_o,
  output logic [COLOR_W-1:0]  glyph_color_o,
  output logic                last_of_run_o
);

  cfg_t      cfg_q;
  cfg_load_t load;
  logic      wr_en;
  logic [2:0] reg_idx;
  logic      push, full, pop, head_valid;
  cmd_t      cmd, head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  assign load.load_x = wr_en && reg_idx == REG_START_X;
  assign load.load_y = wr_en && reg_idx == REG_START_Y;
  assign load.start  = pwdata[CFG_W-1:0];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_X:     cfg_q.start_x     <= pwdata[CFG_W-1:0];
        REG_START_Y:     cfg_q.start_y     <= pwdata[CFG_W-1:0];
        REG_WIDE_BASE:   cfg_q.wide_base   <= pwdata;
        REG_NARROW_BASE: cfg_q.narrow_base <= pwdata;
        REG_INK:         cfg_q.ink         <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_START_X:     prdata = PDATA_W'(unsigned'(cfg_q.start_x));
      REG_START_Y:     prdata = PDATA_W'(unsigned'(cfg_q.start_y));
      REG_WIDE_BASE:   prdata = cfg_q.wide_base;
      REG_NARROW_BASE: prdata = cfg_q.narrow_base;
      REG_INK:         prdata = PDATA_W'(cfg_q.ink);
      default:         prdata = '0;
    endcase
  end

  gtgl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  gtgl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  gtgl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .cfg_i           (cfg_q),
    .load_i          (load),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pen_x_o         (pen_x_o),
    .pen_y_o         (pen_y_o),
    .glyph_width_o   (glyph_width_o),
    .glyph_address_o (glyph_address_o),
    .is_wide_o       (is_wide_o),
    .glyph_color_o   (glyph_color_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gb2312_text_glyph_layout_core
// Feeds text through the byte channel and checks every glyph beat against a
// layout predictor. A directed table opens the run. Random phases follow,
// each with its own register setting and idle/stall pattern.
// ----------------------------------------------------------------------------
module testbench;
  import gtgl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [GWIDTH_W-1:0]   width;
    logic [ADDR_W-1:0]     addr;
    logic                  wide;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } glyph_cmd_t;

  typedef struct {
    logic [7:0] text;
    bit         typed;
    glyph_cmd_t cmd;
  } text_row_t;

  localparam int PHASES       = 9;
  localparam int PHASE_BYTES  = 150;
  localparam int SETTLE_WAIT  = 10;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic [7:0]          text_byte_i  = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  coord_t              pen_x_o;
  coord_t              pen_y_o;
  logic [GWIDTH_W-1:0] glyph_width_o;
  logic [ADDR_W-1:0]   glyph_address_o;
  logic                is_wide_o;
  logic [COLOR_W-1:0]  glyph_color_o;
  logic                last_of_run_o;

  gb2312_text_glyph_layout_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .text_byte_i     (text_byte_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pen_x_o         (pen_x_o),
    .pen_y_o         (pen_y_o),
    .glyph_width_o   (glyph_width_o),
    .glyph_address_o (glyph_address_o),
    .is_wide_o       (is_wide_o),
    .glyph_color_o   (glyph_color_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Layout predictor state
  longint      cfg_start_x, cfg_start_y;
  logic [31:0] cfg_wide_base, cfg_narrow_base;
  logic [23:0] cfg_ink;
  longint      pen_x, pen_y;
  logic [7:0]  held_byte;
  bit          held_ok;

  glyph_cmd_t  glyph_queue[$];
  text_row_t   directed_rows[$];
  logic [7:0]  pending_text[$];
  int          fail_count;
  int          idle_pct;
  int          stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint clamp_pen(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic glyph_cmd_t mk_cmd(coord_t x, coord_t y, logic [GWIDTH_W-1:0] w,
                                        logic [31:0] addr, logic wide, logic [23:0] color,
                                        logic last);
    glyph_cmd_t c;
    c.x     = x;
    c.y     = y;
    c.width = w;
    c.addr  = addr;
    c.wide  = wide;
    c.color = color;
    c.last  = last;
    return c;
  endfunction

  // Draw one glyph at the pen, then advance the pen
  function automatic void push_glyph(bit wide, logic [31:0] addr);
    glyph_queue.push_back(mk_cmd(coord_t'(pen_x), coord_t'(pen_y),
                                 wide ? WIDTH_WIDE : WIDTH_NARROW, addr, wide, cfg_ink, 1'b0));
    pen_x = clamp_pen(pen_x + (wide ? longint'(ADV_WIDE) : longint'(ADV_NARROW)));
  endfunction

  // Work out the glyphs caused by one text byte
  function automatic void predict_glyphs(logic [7:0] b);
    int          first;
    logic [31:0] row_idx, cell_idx;
    glyph_cmd_t  tail;
    first = glyph_queue.size();
    if (held_ok) begin
      held_ok = 1'b0;
      if (b >= LEAD_MIN) begin
        row_idx  = 32'(held_byte) - 32'(CODE_BIAS);
        cell_idx = 32'(b) - 32'(CODE_BIAS);
        push_glyph(1'b1, cfg_wide_base + (cell_idx + row_idx * ROW_CELLS) * WIDE_BYTES);
        held_byte = '0;
      end else begin
        push_glyph(1'b0, cfg_narrow_base + 32'(held_byte) * NARROW_BYTES);
        held_byte = '0;
        if (b == BYTE_NUL) begin
          pen_x = clamp_pen(cfg_start_x);
          pen_y = clamp_pen(cfg_start_y);
        end else if (b == BYTE_LF) begin
          pen_y = clamp_pen(pen_y + longint'(LINE_STEP));
          pen_x = clamp_pen(cfg_start_x);
        end else begin
          push_glyph(1'b0, cfg_narrow_base + 32'(b) * NARROW_BYTES);
        end
      end
    end else if (b >= LEAD_MIN) begin
      held_byte = b;
      held_ok   = 1'b1;
    end else if (b == BYTE_NUL) begin
      pen_x = clamp_pen(cfg_start_x);
      pen_y = clamp_pen(cfg_start_y);
    end else if (b == BYTE_LF) begin
      pen_y = clamp_pen(pen_y + longint'(LINE_STEP));
      pen_x = clamp_pen(cfg_start_x);
    end else begin
      push_glyph(1'b0, cfg_narrow_base + 32'(b) * NARROW_BYTES);
    end
    // Flag the final glyph of this byte
    if (glyph_queue.size() > first) begin
      tail = glyph_queue.pop_back();
      tail.last = 1'b1;
      glyph_queue.push_back(tail);
    end
  endfunction

  function automatic void load_layout_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_START_X: begin
        cfg_start_x = longint'($signed(v[15:0]));
        pen_x = clamp_pen(cfg_start_x);
      end
      REG_START_Y: begin
        cfg_start_y = longint'($signed(v[15:0]));
        pen_y = clamp_pen(cfg_start_y);
      end
      REG_WIDE_BASE:   cfg_wide_base   = v;
      REG_NARROW_BASE: cfg_narrow_base = v;
      REG_INK:         cfg_ink         = v[23:0];
      default: ;
    endcase
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: glyph %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each glyph beat against the oldest expectation
  always @(posedge clk_i) begin
    glyph_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (glyph_queue.size() == 0) begin
        $display("%0t ns: unexpected glyph beat, expected none, got addr %0h",
                 $time, glyph_address_o);
        fail_count++;
      end else begin
        want = glyph_queue.pop_front();
        report_field("pen_x", 32'(want.x), 32'(pen_x_o));
        report_field("pen_y", 32'(want.y), 32'(pen_y_o));
        report_field("width", 32'(want.width), 32'(glyph_width_o));
        report_field("address", want.addr, glyph_address_o);
        report_field("is_wide", 32'(want.wide), 32'(is_wide_o));
        report_field("color", 32'(want.color), 32'(glyph_color_o));
        report_field("last", 32'(want.last), 32'(last_of_run_o));
      end
    end
  end

  // Random back pressure on the glyph channel
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    load_layout_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Send one text beat; hold it until accepted, then predict
  task automatic send_text(logic [7:0] b, bit typed, glyph_cmd_t cmd);
    int first;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i  <= 1'b0;
      text_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    first = glyph_queue.size();
    predict_glyphs(b);
    if (typed) begin
      while (glyph_queue.size() > first) void'(glyph_queue.pop_back());
      glyph_queue.push_back(cmd);
    end
  endtask

  // Drop valid, wait for all glyphs, then let the back end settle
  task automatic drain_glyphs();
    in_valid_i <= 1'b0;
    while (glyph_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  function automatic void add_row(logic [7:0] t, bit typed, glyph_cmd_t c);
    text_row_t r;
    r.text  = t;
    r.typed = typed;
    r.cmd   = c;
    directed_rows.push_back(r);
  endfunction

  // Mostly well-formed text: GB2312 pairs, ASCII, line breaks, string ends;
  // the rest is noise and broken pairs
  function automatic void push_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      pending_text.push_back(8'($urandom_range(161, 247)));
      pending_text.push_back(8'($urandom_range(161, 254)));
    end else if (pick < 62) begin
      pending_text.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 70) begin
      pending_text.push_back(BYTE_LF);
    end else if (pick < 75) begin
      pending_text.push_back(BYTE_NUL);
    end else if (pick < 87) begin
      pending_text.push_back(8'($urandom));
    end else if (pick < 95) begin
      pending_text.push_back(8'($urandom_range(160, 255)));
      case ($urandom_range(2))
        0:       pending_text.push_back(BYTE_NUL);
        1:       pending_text.push_back(BYTE_LF);
        default: pending_text.push_back(8'($urandom_range(1, 159)));
      endcase
    end else begin
      pending_text.push_back($urandom_range(1) ? 8'hA0 : 8'hFF);
      pending_text.push_back($urandom_range(1) ? 8'hA0 : 8'hFF);
    end
  endfunction

  task automatic set_phase_regs(int phase);
    logic [15:0] sx, sy;
    logic [31:0] wb, nb;
    logic [23:0] ink;
    sx  = 16'($urandom);
    sy  = 16'($urandom);
    wb  = $urandom;
    nb  = $urandom;
    ink = 24'($urandom);
    case (phase)
      0: begin
        sx = 16'h7FFF; sy = 16'h7FFF; wb = '1; nb = '1; ink = '1;
      end
      1: begin
        sx = 16'h8000; sy = 16'h8000; wb = '0; nb = '0; ink = '0;
      end
      2: begin
        // Pen close to the top so advances and line steps saturate
        sx = 16'h7FFF - 16'($urandom_range(150));
        sy = 16'h7FFF - 16'($urandom_range(300));
      end
      default: ;
    endcase
    reg_write(REG_START_X, {{16{sx[15]}}, sx});
    reg_write(REG_START_Y, {{16{sy[15]}}, sy});
    reg_write(REG_WIDE_BASE, wb);
    reg_write(REG_NARROW_BASE, nb);
    reg_write(REG_INK, {8'h00, ink});
  endtask

  initial begin
    fail_count      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    cfg_start_x     = 0;
    cfg_start_y     = 0;
    cfg_wide_base   = '0;
    cfg_narrow_base = '0;
    cfg_ink         = '0;
    pen_x           = 0;
    pen_y           = 0;
    held_byte       = '0;
    held_ok         = 1'b0;

    // Directed text at reset settings; typed rows read straight off the rules
    add_row(8'h01, 1, mk_cmd(16'sd0, 16'sd0, WIDTH_NARROW, 32'd12, 1'b0, '0, 1'b1));
    add_row(8'h9F, 1, mk_cmd(16'sd6, 16'sd0, WIDTH_NARROW, 32'd1908, 1'b0, '0, 1'b1));
    add_row(BYTE_LF, 0, '0);
    add_row(8'hFF, 0, '0);
    add_row(8'hFF, 1, mk_cmd(16'sd0, 16'sd12, WIDTH_WIDE, 32'd214320, 1'b1, '0, 1'b1));
    add_row(8'hA0, 0, '0);
    // Lead and second of 160 wrap the offset below zero
    add_row(8'hA0, 1, mk_cmd(16'sd13, 16'sd12, WIDTH_WIDE, 32'hFFFF_F718, 1'b1, '0, 1'b1));
    add_row(8'hA1, 0, '0);
    add_row(8'h41, 0, '0);
    add_row(8'hB0, 0, '0);
    add_row(BYTE_NUL, 0, '0);
    add_row(8'hC0, 0, '0);
    add_row(BYTE_LF, 0, '0);
    add_row(BYTE_NUL, 0, '0);
    add_row(8'h80, 0, '0);
    add_row(8'h7F, 0, '0);
    add_row(8'hA0, 0, '0);
    add_row(8'h9F, 0, '0);
    add_row(8'hA1, 0, '0);
    add_row(8'hFE, 0, '0);
    add_row(8'hB5, 0, '0);
    add_row(8'h55, 0, '0);
    add_row(BYTE_NUL, 0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_text(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].cmd);
    end
    drain_glyphs();

    // Random phases, each with fresh settings and its own idle pattern
    for (int p = 0; p < PHASES; p++) begin
      stall_pct = 0;
      set_phase_regs(p);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      while (pending_text.size() < PHASE_BYTES) push_token();
      while (pending_text.size() != 0) begin
        send_text(pending_text.pop_front(), 0, '0);
      end
      drain_glyphs();
    end

    if (fail_count == 0 && glyph_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/gtgl_pkg.sv
rtl/gtgl_front.sv
rtl/gtgl_queue.sv
rtl/gtgl_back.sv
rtl/gb2312_text_glyph_layout_core.sv
verif/testbench.sv
